FILE: hdl/gls_pkg.sv
// ----------------------------------------------------------------------------
// gls_pkg
// Shared widths, constants and register codes of the gauge level smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package gls_pkg;

    // field widths
    localparam int FS_W       = 24;
    localparam int ST_W       = 16;
    localparam int RAW_W      = 24;
    localparam int TT_W       = 16;
    localparam int LVL_W      = 16;
    localparam int SPD_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    // serial arithmetic units
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 40;
    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = 25;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    localparam logic [LVL_W-1:0] LEVEL_ONE = 16'd32768;
    localparam logic [24:0]      X_CAP     = 25'h100_0000;

    // 0.48 and 0.235 in Q16
    localparam logic [MUL_B_W-1:0] K_X2 = 25'd31457;
    localparam logic [MUL_B_W-1:0] K_X3 = 25'd15401;

    localparam logic [FS_W-1:0] FS_RESET = 24'd100;
    localparam logic [ST_W-1:0] ST_RESET = 16'd1229;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FULL_SCALE  = 1'b0,
        REG_SMOOTH_TIME = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

FILE: hdl/gls_chan_if.sv
// ----------------------------------------------------------------------------
// gls_chan_if
// Valid/ready channels of the gauge level smoother: items in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gls_in_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [gls_pkg::RAW_W-1:0]    raw_value;
    logic        [gls_pkg::TT_W-1:0]     tick_time;

    modport source (output valid, cmd, raw_value, tick_time, input ready);
    modport sink   (input valid, cmd, raw_value, tick_time, output ready);
endinterface

interface gls_out_if;
    logic                          valid;
    logic                          ready;
    logic [gls_pkg::LVL_W-1:0]     gauge_level;
    logic [gls_pkg::LVL_W-1:0]     trailing_level;

    modport source (output valid, gauge_level, trailing_level, input ready);
    modport sink   (input valid, gauge_level, trailing_level, output ready);
endinterface

`default_nettype wire

FILE: hdl/gls_sdiv.sv
// ----------------------------------------------------------------------------
// gls_sdiv
// Bit-serial restoring divider: one quotient bit per cycle, floor quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module gls_sdiv #(
    parameter int NUM_W = gls_pkg::DIV_NUM_W,
    parameter int DEN_W = gls_pkg::DIV_DEN_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] q_reg, q_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign shifted = {rem_reg, q_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            rem_next  = '0;
            den_next  = den;
            q_next    = num;
        end
        else if (busy_reg)
        begin
            // numerator shifts out at the top, quotient bits enter at the bottom
            rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            q_next   = {q_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

FILE: hdl/gls_smul.sv
// ----------------------------------------------------------------------------
// gls_smul
// Bit-serial shift-add multiplier: one multiplier bit per cycle, lsb first.
// ----------------------------------------------------------------------------
`default_nettype none

module gls_smul #(
    parameter int A_W = gls_pkg::MUL_A_W,
    parameter int B_W = gls_pkg::MUL_B_W
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [A_W-1:0]       a,
    input  wire logic [B_W-1:0]       b,
    output logic                      done,
    output logic      [A_W+B_W-1:0]   prod
);

    localparam int CNT_W = $clog2(B_W);
    localparam int P_W   = A_W + B_W;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [P_W-1:0]   p_reg, p_next;

    logic [A_W:0]     sum;

    assign sum = {1'b0, p_reg[P_W-1:B_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        p_next    = p_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(B_W - 1);
            a_next    = a;
            p_next    = {{A_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            // partial sum enters at the top while the multiplier drains out below
            p_next   = {sum, p_reg[B_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        p_reg <= p_next;
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

`default_nettype wire

FILE: hdl/gauge_level_smooth_damp_top.sv
// ----------------------------------------------------------------------------
// gauge_level_smooth_damp_top
// Gauge level with a critically damped trailing level, serial arithmetic.
// ----------------------------------------------------------------------------
// One item is worked on at a time and each item gives one result. A set item
// with a positive raw value and a non-zero full scale goes through the
// bit-serial divider (48 quotient bits, one per cycle). A tick runs four
// divides and seven multiplies (25 multiplier bits, one per cycle) one after
// another in the sequencer. A set item with a non-positive raw value or a zero
// full scale, a tick with zero elapsed time and a tick with zero smoothing
// time go straight to the done state. A finished result sits in the output
// register, so the next item is taken while it waits.
`default_nettype none

module gauge_level_smooth_damp_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    gls_in_if.sink                                 din,
    gls_out_if.source                              dout,
    input  wire logic                              cfg_we,
    input  wire logic [gls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gls_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [13:0] {
        S_IDLE = 14'h0001,
        S_SDIV = 14'h0002,
        S_X    = 14'h0004,
        S_X2   = 14'h0008,
        S_X3   = 14'h0010,
        S_P2   = 14'h0020,
        S_P3   = 14'h0040,
        S_E    = 14'h0080,
        S_OC   = 14'h0100,
        S_TMP  = 14'h0200,
        S_OT   = 14'h0400,
        S_VN   = 14'h0800,
        S_OUT  = 14'h1000,
        S_DONE = 14'h2000
    } state_t;

    state_t state_reg, state_next;
    logic   launch_reg, launch_next;
    logic   ovalid_reg, ovalid_next;

    logic        [gls_pkg::FS_W-1:0]   full_scale_reg, full_scale_next;
    logic        [gls_pkg::ST_W-1:0]   smooth_time_reg, smooth_time_next;
    logic        [gls_pkg::LVL_W-1:0]  level_now_reg, level_now_next;
    logic        [gls_pkg::LVL_W-1:0]  level_trail_reg, level_trail_next;
    logic signed [gls_pkg::SPD_W-1:0]  trail_speed_reg, trail_speed_next;

    logic        [gls_pkg::LVL_W-1:0]  gauge_out_reg, gauge_out_next;
    logic        [gls_pkg::LVL_W-1:0]  trail_out_reg, trail_out_next;

    logic signed [gls_pkg::RAW_W-1:0]  raw_reg, raw_next;
    logic        [gls_pkg::TT_W-1:0]   tt_reg, tt_next;
    logic        [24:0]                x_reg, x_next;
    logic        [32:0]                x2_reg, x2_next;
    logic        [40:0]                x3_reg, x3_next;
    logic        [39:0]                d_reg, d_next;
    logic        [16:0]                e_reg, e_next;
    logic signed [17:0]                change_reg, change_next;
    logic signed [33:0]                s_reg, s_next;
    logic signed [42:0]                tmp_reg, tmp_next;
    logic signed [47:0]                ot_reg, ot_next;
    logic signed [31:0]                vn_reg, vn_next;

    logic                              div_start, div_done;
    logic [gls_pkg::DIV_NUM_W-1:0]     div_num, div_quo;
    logic [gls_pkg::DIV_DEN_W-1:0]     div_den;
    logic                              mul_start, mul_done;
    logic [gls_pkg::MUL_A_W-1:0]       mul_a;
    logic [gls_pkg::MUL_B_W-1:0]       mul_b;
    logic [gls_pkg::MUL_P_W-1:0]       mul_prod;

    logic                              in_xfer;
    logic [14:0]                       st_half;
    logic signed [17:0]                chg_raw;
    logic signed [20:0]                maxc, neg_maxc, chg_wide;
    logic signed [17:0]                chg_clamped;
    logic [17:0]                       chg_mag;
    logic [33:0]                       s_mag;
    logic [42:0]                       tmp_mag;
    logic signed [48:0]                vmot;
    logic [48:0]                       vmot_mag;
    logic signed [43:0]                cterm;
    logic [43:0]                       cterm_mag;
    logic [gls_pkg::MUL_P_W:0]         rnd16_sum, rnd8_sum, rnd25_sum;
    logic [57:0]                       rnd16;
    logic [65:0]                       rnd8;
    logic [48:0]                       rnd25;
    logic signed [33:0]                oc;
    logic [42:0]                       tmp_new_mag;
    logic signed [35:0]                term;
    logic signed [36:0]                out_wide;
    logic                              rising, passed;

    gls_sdiv #(
        .NUM_W (gls_pkg::DIV_NUM_W),
        .DEN_W (gls_pkg::DIV_DEN_W)
    ) u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    gls_smul #(
        .A_W (gls_pkg::MUL_A_W),
        .B_W (gls_pkg::MUL_B_W)
    ) u_smul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign din.ready = (state_reg == S_IDLE);
    assign in_xfer   = din.valid && din.ready;

    assign dout.valid          = ovalid_reg;
    assign dout.gauge_level    = gauge_out_reg;
    assign dout.trailing_level = trail_out_reg;

    assign st_half = smooth_time_reg[gls_pkg::ST_W-1:1];

    // change = trail - target, limited to +-16*smooth_time
    assign chg_raw  = $signed({2'b00, level_trail_reg}) - $signed({2'b00, level_now_reg});
    assign maxc     = $signed({1'b0, smooth_time_reg, 4'b0000});
    assign neg_maxc = -maxc;
    assign chg_wide = {{3{chg_raw[17]}}, chg_raw};

    always_comb
    begin
        if (chg_wide > maxc)
            chg_clamped = maxc[17:0];
        else if (chg_wide < neg_maxc)
            chg_clamped = neg_maxc[17:0];
        else
            chg_clamped = chg_raw;
    end

    assign chg_mag  = change_reg[17] ? $unsigned(-change_reg) : $unsigned(change_reg);
    assign s_mag    = s_reg[33] ? $unsigned(-s_reg) : $unsigned(s_reg);
    assign tmp_mag  = tmp_reg[42] ? $unsigned(-tmp_reg) : $unsigned(tmp_reg);
    assign vmot     = $signed({{17{trail_speed_reg[31]}}, trail_speed_reg})
                    - $signed({ot_reg[47], ot_reg});
    assign vmot_mag = vmot[48] ? $unsigned(-vmot) : $unsigned(vmot);
    assign cterm    = $signed({{17{change_reg[17]}}, change_reg, 9'b0})
                    + $signed({tmp_reg[42], tmp_reg});
    assign cterm_mag = cterm[43] ? $unsigned(-cterm) : $unsigned(cterm);

    // round half away from zero on magnitudes
    assign rnd16_sum = {1'b0, mul_prod} + ((gls_pkg::MUL_P_W + 1)'(1) << 15);
    assign rnd8_sum  = {1'b0, mul_prod} + ((gls_pkg::MUL_P_W + 1)'(1) << 7);
    assign rnd25_sum = {1'b0, mul_prod} + ((gls_pkg::MUL_P_W + 1)'(1) << 24);
    assign rnd16     = rnd16_sum[gls_pkg::MUL_P_W:16];
    assign rnd8      = rnd8_sum[gls_pkg::MUL_P_W:8];
    assign rnd25     = rnd25_sum[gls_pkg::MUL_P_W:25];

    assign oc = change_reg[17] ? -$signed({1'b0, div_quo[32:0]})
                               : $signed({1'b0, div_quo[32:0]});
    assign tmp_new_mag = {1'b0, rnd8[41:0]};
    assign term = cterm[43] ? -$signed({1'b0, rnd25[34:0]}) : $signed({1'b0, rnd25[34:0]});
    assign out_wide = $signed({21'b0, level_trail_reg})
                    - $signed({{19{change_reg[17]}}, change_reg})
                    + $signed({term[35], term});
    assign rising = level_now_reg > level_trail_reg;
    assign passed = out_wide > $signed({21'b0, level_now_reg});

    // operand select for the shared units
    always_comb
    begin
        div_num = '0;
        div_den = {24'b0, smooth_time_reg};
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            S_SDIV:
            begin
                div_num = {10'b0, raw_reg[22:0], 15'b0};
                div_den = {16'b0, full_scale_reg};
            end
            S_X:   div_num = {19'b0, tt_reg, 13'b0} + {33'b0, st_half};
            S_E:
            begin
                div_num = 48'h1_0000_0000 + {9'b0, d_reg[39:1]};
                div_den = d_reg;
            end
            S_OC:  div_num = {17'b0, chg_mag[16:0], 14'b0} + {33'b0, st_half};
            S_OT:  div_num = {tmp_mag, 5'b0} + {33'b0, st_half};
            S_X2:
            begin
                mul_a = {23'b0, x_reg};
                mul_b = x_reg;
            end
            S_X3:
            begin
                mul_a = {15'b0, x2_reg};
                mul_b = x_reg;
            end
            S_P2:
            begin
                mul_a = {15'b0, x2_reg};
                mul_b = gls_pkg::K_X2;
            end
            S_P3:
            begin
                mul_a = {7'b0, x3_reg};
                mul_b = gls_pkg::K_X3;
            end
            S_TMP:
            begin
                mul_a = {14'b0, s_mag};
                mul_b = {9'b0, tt_reg};
            end
            S_VN:
            begin
                mul_a = vmot_mag[47:0];
                mul_b = {8'b0, e_reg};
            end
            S_OUT:
            begin
                mul_a = {4'b0, cterm_mag};
                mul_b = {8'b0, e_reg};
            end
            default: ;
        endcase
    end

    assign div_start = launch_reg && (state_reg inside {S_SDIV, S_X, S_E, S_OC, S_OT});
    assign mul_start = launch_reg &&
                       (state_reg inside {S_X2, S_X3, S_P2, S_P3, S_TMP, S_VN, S_OUT});

    always_comb
    begin
        state_next       = state_reg;
        launch_next      = 1'b0;
        ovalid_next      = ovalid_reg;
        full_scale_next  = full_scale_reg;
        smooth_time_next = smooth_time_reg;
        level_now_next   = level_now_reg;
        level_trail_next = level_trail_reg;
        trail_speed_next = trail_speed_reg;
        gauge_out_next   = gauge_out_reg;
        trail_out_next   = trail_out_reg;
        raw_next         = raw_reg;
        tt_next          = tt_reg;
        x_next           = x_reg;
        x2_next          = x2_reg;
        x3_next          = x3_reg;
        d_next           = d_reg;
        e_next           = e_reg;
        change_next      = change_reg;
        s_next           = s_reg;
        tmp_next         = tmp_reg;
        ot_next          = ot_reg;
        vn_next          = vn_reg;

        if (cfg_we)
        begin
            case (gls_pkg::cfg_reg_t'(cfg_index))
                gls_pkg::REG_FULL_SCALE:  full_scale_next  = cfg_data[gls_pkg::FS_W-1:0];
                gls_pkg::REG_SMOOTH_TIME: smooth_time_next = cfg_data[gls_pkg::ST_W-1:0];
                default: ;
            endcase
        end

        if (ovalid_reg && dout.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    raw_next = din.raw_value;
                    tt_next  = din.tick_time;
                    if (din.cmd == gls_pkg::CMD_SET)
                    begin
                        if (din.raw_value[gls_pkg::RAW_W-1] || din.raw_value == '0)
                        begin
                            level_now_next = '0;
                            state_next     = S_DONE;
                        end
                        else if (full_scale_reg == '0)
                        begin
                            // epsilon floor: any positive value is full scale
                            level_now_next = gls_pkg::LEVEL_ONE;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            state_next  = S_SDIV;
                            launch_next = 1'b1;
                        end
                    end
                    else if (din.tick_time == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (smooth_time_reg == '0)
                    begin
                        level_trail_next = level_now_reg;
                        trail_speed_next = '0;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        change_next = chg_clamped;
                        state_next  = S_X;
                        launch_next = 1'b1;
                    end
                end
            end
            S_SDIV:
            begin
                if (div_done)
                begin
                    level_now_next = (div_quo > 48'(gls_pkg::LEVEL_ONE)) ?
                                     gls_pkg::LEVEL_ONE : div_quo[15:0];
                    state_next     = S_DONE;
                end
            end
            S_X:
            begin
                if (div_done)
                begin
                    x_next      = (div_quo > 48'(gls_pkg::X_CAP)) ? gls_pkg::X_CAP
                                                                  : div_quo[24:0];
                    state_next  = S_X2;
                    launch_next = 1'b1;
                end
            end
            S_X2:
            begin
                if (mul_done)
                begin
                    x2_next     = rnd16[32:0];
                    state_next  = S_X3;
                    launch_next = 1'b1;
                end
            end
            S_X3:
            begin
                if (mul_done)
                begin
                    x3_next     = rnd16[40:0];
                    state_next  = S_P2;
                    launch_next = 1'b1;
                end
            end
            S_P2:
            begin
                if (mul_done)
                begin
                    d_next      = 40'd65536 + {15'b0, x_reg} + {8'b0, rnd16[31:0]};
                    state_next  = S_P3;
                    launch_next = 1'b1;
                end
            end
            S_P3:
            begin
                if (mul_done)
                begin
                    d_next      = d_reg + {1'b0, rnd16[38:0]};
                    state_next  = S_E;
                    launch_next = 1'b1;
                end
            end
            S_E:
            begin
                if (div_done)
                begin
                    e_next      = div_quo[16:0];
                    state_next  = S_OC;
                    launch_next = 1'b1;
                end
            end
            S_OC:
            begin
                if (div_done)
                begin
                    s_next      = $signed({{2{trail_speed_reg[31]}}, trail_speed_reg}) + oc;
                    state_next  = S_TMP;
                    launch_next = 1'b1;
                end
            end
            S_TMP:
            begin
                if (mul_done)
                begin
                    tmp_next    = s_reg[33] ? -$signed(tmp_new_mag) : $signed(tmp_new_mag);
                    state_next  = S_OT;
                    launch_next = 1'b1;
                end
            end
            S_OT:
            begin
                if (div_done)
                begin
                    ot_next     = tmp_reg[42] ? -$signed({1'b0, div_quo[46:0]})
                                              : $signed({1'b0, div_quo[46:0]});
                    state_next  = S_VN;
                    launch_next = 1'b1;
                end
            end
            S_VN:
            begin
                if (mul_done)
                begin
                    // saturate the new velocity to the signed 32-bit range
                    if (vmot[48])
                        vn_next = (rnd16 > 58'd2147483648) ? 32'sh8000_0000
                                                          : $signed(32'd0 - rnd16[31:0]);
                    else
                        vn_next = (rnd16 > 58'd2147483647) ? 32'sh7fff_ffff
                                                          : $signed(rnd16[31:0]);
                    state_next  = S_OUT;
                    launch_next = 1'b1;
                end
            end
            S_OUT:
            begin
                if (mul_done)
                begin
                    if (rising == passed)
                    begin
                        // target reached or passed: land on it and stop
                        level_trail_next = level_now_reg;
                        trail_speed_next = '0;
                    end
                    else
                    begin
                        trail_speed_next = vn_reg;
                        if (out_wide < 0)
                            level_trail_next = '0;
                        else if (out_wide > $signed(37'(gls_pkg::LEVEL_ONE)))
                            level_trail_next = gls_pkg::LEVEL_ONE;
                        else
                            level_trail_next = out_wide[15:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || dout.ready)
                begin
                    ovalid_next    = 1'b1;
                    gauge_out_next = level_now_reg;
                    trail_out_next = level_trail_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            launch_reg      <= 1'b0;
            ovalid_reg      <= 1'b0;
            full_scale_reg  <= gls_pkg::FS_RESET;
            smooth_time_reg <= gls_pkg::ST_RESET;
            level_now_reg   <= '0;
            level_trail_reg <= '0;
            trail_speed_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            launch_reg      <= launch_next;
            ovalid_reg      <= ovalid_next;
            full_scale_reg  <= full_scale_next;
            smooth_time_reg <= smooth_time_next;
            level_now_reg   <= level_now_next;
            level_trail_reg <= level_trail_next;
            trail_speed_reg <= trail_speed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gauge_out_reg <= gauge_out_next;
        trail_out_reg <= trail_out_next;
        raw_reg       <= raw_next;
        tt_reg        <= tt_next;
        x_reg         <= x_next;
        x2_reg        <= x2_next;
        x3_reg        <= x3_next;
        d_reg         <= d_next;
        e_reg         <= e_next;
        change_reg    <= change_next;
        s_reg         <= s_next;
        tmp_reg       <= tmp_next;
        ot_reg        <= ot_next;
        vn_reg        <= vn_next;
    end

    // divider results only come back while a divide step is waiting
    a_div_step: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_SDIV || state_reg == S_X || state_reg == S_E ||
                      state_reg == S_OC || state_reg == S_OT))
        else $error("divider finished outside a divide step");

    a_mul_step: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_X2 || state_reg == S_X3 || state_reg == S_P2 ||
                      state_reg == S_P3 || state_reg == S_TMP || state_reg == S_VN ||
                      state_reg == S_OUT))
        else $error("multiplier finished outside a multiply step");

    a_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != S_IDLE))
        else $error("accepted item left no work in progress");

    a_trail_range: assert property (@(posedge clk) disable iff (!rst_n)
        (level_trail_reg <= gls_pkg::LEVEL_ONE) && (level_now_reg <= gls_pkg::LEVEL_ONE))
        else $error("level above full scale");

endmodule

`default_nettype wire
